FILE: design/sct_pkg.sv
// Shared types, constants and command codes for the scaled clock timer scheduler.
// No dependencies.
package sct_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int MAX_FIRES = 63;
    localparam int FIRE_W    = 6;
    localparam int FRAC_BITS = 16;
    localparam int TIME_W    = 48;
    localparam int HANDLE_W  = 31;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADVANCE = 2'd0,
        CMD_ADD_ONE = 2'd1,
        CMD_ADD_REP = 2'd2,
        CMD_CANCEL  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_FIRED    = 3'd0,
        KIND_ADDED    = 3'd1,
        KIND_REFUSED  = 3'd2,
        KIND_FULL     = 3'd3,
        KIND_CANCELED = 3'd4,
        KIND_NOTFOUND = 3'd5,
        KIND_DONE     = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCAN,
        ST_PICK,
        ST_FIRE,
        ST_DAY,
        ST_OUT,
        ST_WAIT
    } state_t;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_GAME  = 2'd1;
    localparam logic [1:0] REG_REAL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic    load;       // capture input beat
        logic    mul_start;
        logic    div_start;  // start scaled increment divide
        logic    add_inc;
        logic    scan_start;
        logic    fire;       // emit best, update slot
        logic    do_cmd;     // execute add / cancel
        logic    day_start;  // start day/time-of-day divide
        logic    set_done;   // result kind advance done
        logic    out_load;
    } dp_ctrl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t    cmd;
        logic    mul_busy;
        logic    div_busy;
        logic    scan_busy;
        logic    found;
        logic    day_busy;
    } dp_stat_t;

    function automatic logic [3:0] speed_mult(input logic [2:0] mode);
        logic [3:0] m;
        m = 4'd1;
        case (mode)
            3'd0:    m = 4'd0;
            3'd2:    m = 4'd2;
            3'd3:    m = 4'd4;
            3'd4:    m = 4'd8;
            default: m = 4'd1;
        endcase
        return m;
    endfunction

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

FILE: design/sct_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// No dependencies.
module sct_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        busy,
    output logic [63:0] quotient,
    output logic [39:0] remainder
);
    logic [63:0] quot_reg, quot_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [40:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[39:0], quot_reg[63]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = trial - {1'b0, dsr_reg};
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[39:0];
endmodule

FILE: design/sct_datapath.sv
// Datapath: slot table, game time, scaling multiply, shared divider, earliest-due scan.
// Depends on sct_pkg and sct_div.
module sct_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sct_pkg::dp_ctrl_t            ctrl,
    output sct_pkg::dp_stat_t            stat,
    input  logic [1:0]                   cmd,
    input  logic [31:0]                  real_delta,
    input  logic [47:0]                  due_time,
    input  logic [47:0]                  period,
    input  logic [30:0]                  target_handle,
    input  logic [2:0]                   speed_mode,
    input  logic [19:0]                  game_seconds_per_day,
    input  logic [19:0]                  real_seconds_per_day,
    output logic [2:0]                   kind,
    output logic [30:0]                  handle,
    output logic [47:0]                  now_time,
    output logic [31:0]                  day_index,
    output logic [35:0]                  time_of_day
);
    localparam int SW = sct_pkg::SLOT_W;

    logic [sct_pkg::SLOTS-1:0]    valid_reg, valid_next;
    logic [47:0]                  due_reg  [sct_pkg::SLOTS];
    logic [47:0]                  per_reg  [sct_pkg::SLOTS];
    logic [30:0]                  hdl_reg  [sct_pkg::SLOTS];

    logic [47:0] time_reg;
    logic [30:0] nh_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] delta_reg;
    logic [47:0] due_in_reg, per_in_reg;
    logic [30:0] tgt_reg;

    // multiply: delta * mult * gspd, two registered steps
    logic [35:0] dm_reg;
    logic [55:0] prod_reg;
    logic [1:0]  mul_cnt_reg;

    // scan
    logic [SW:0]    scan_idx_reg;
    logic           best_ok_reg;
    logic [SW-1:0]  best_reg;
    logic [47:0]    best_due_reg;
    logic [30:0]    best_age_reg;

    // result
    logic [2:0]  kind_reg;
    logic [30:0] handle_reg;
    logic [47:0] now_reg;
    logic [31:0] day_reg;
    logic [35:0] tod_reg;

    logic        div_start;
    logic [63:0] div_a;
    logic [39:0] div_b;
    logic        div_busy;
    logic [63:0] div_q;
    logic [39:0] div_r;
    logic        div_day_reg;
    logic        day_zero_reg;

    logic [SW-1:0] cur;
    logic [30:0]   cur_age;
    logic          cand;
    logic          free_ok;
    logic [SW-1:0] free_idx;
    logic          match_any;
    logic [sct_pkg::SLOTS-1:0] match_vec;
    logic [2:0]    cmd_kind;
    logic [30:0]   cmd_handle;

    assign cur     = scan_idx_reg[SW-1:0];
    assign cur_age = nh_reg - hdl_reg[cur];
    assign cand    = valid_reg[cur] && (due_reg[cur] <= time_reg)
                     && (!best_ok_reg || due_reg[cur] < best_due_reg
                         || (due_reg[cur] == best_due_reg && cur_age > best_age_reg));

    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = sct_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = SW'(i);
            end
        end
        for (int i = 0; i < sct_pkg::SLOTS; i++)
        begin
            match_vec[i] = valid_reg[i] && (hdl_reg[i] == tgt_reg);
        end
        match_any = |match_vec;
    end

    always_comb
    begin
        cmd_handle = '0;
        cmd_kind   = sct_pkg::KIND_FULL;
        case (sct_pkg::cmd_t'(cmd_reg))
            sct_pkg::CMD_ADD_ONE:
            begin
                if (free_ok)
                begin
                    cmd_kind   = sct_pkg::KIND_ADDED;
                    cmd_handle = nh_reg;
                end
            end
            sct_pkg::CMD_ADD_REP:
            begin
                if (per_in_reg == '0)
                begin
                    cmd_kind = sct_pkg::KIND_REFUSED;
                end
                else if (free_ok)
                begin
                    cmd_kind   = sct_pkg::KIND_ADDED;
                    cmd_handle = nh_reg;
                end
            end
            default:
            begin
                cmd_kind = match_any ? sct_pkg::KIND_CANCELED : sct_pkg::KIND_NOTFOUND;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.fire && per_reg[best_reg] == '0)
        begin
            valid_next[best_reg] = 1'b0;
        end
        if (ctrl.do_cmd)
        begin
            if (cmd_kind == sct_pkg::KIND_ADDED)
            begin
                valid_next[free_idx] = 1'b1;
            end
            else if (cmd_reg == sct_pkg::CMD_CANCEL)
            begin
                valid_next = valid_reg & ~match_vec;
            end
        end
    end

    always_comb
    begin
        div_start = ctrl.div_start || ctrl.day_start;
        if (ctrl.day_start)
        begin
            div_a = {16'd0, time_reg};
            div_b = {4'd0, game_seconds_per_day, 16'd0};
        end
        else
        begin
            div_a = {8'd0, prod_reg};
            div_b = {20'd0, real_seconds_per_day};
        end
    end

    sct_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            time_reg     <= '0;
            nh_reg       <= '0;
            mul_cnt_reg  <= '0;
            scan_idx_reg <= '0;
            best_ok_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.mul_start)
            begin
                mul_cnt_reg <= 2'd2;
            end
            else if (mul_cnt_reg != 2'd0)
            begin
                mul_cnt_reg <= mul_cnt_reg - 2'd1;
            end
            if (ctrl.add_inc)
            begin
                if (real_seconds_per_day != '0)
                begin
                    time_reg <= sct_pkg::sat_add(time_reg,
                                    (div_q[63:48] != '0) ? sct_pkg::TIME_MAX : div_q[47:0]);
                end
            end
            if (ctrl.scan_start)
            begin
                scan_idx_reg <= '0;
                best_ok_reg  <= 1'b0;
            end
            else if (!scan_idx_reg[SW])
            begin
                scan_idx_reg <= scan_idx_reg + (SW+1)'(1);
                if (cand)
                begin
                    best_ok_reg <= 1'b1;
                end
            end
            if (ctrl.do_cmd && cmd_kind == sct_pkg::KIND_ADDED)
            begin
                nh_reg <= nh_reg + 31'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg    <= cmd;
            delta_reg  <= real_delta;
            due_in_reg <= due_time;
            per_in_reg <= period;
            tgt_reg    <= target_handle;
        end
        if (ctrl.mul_start)
        begin
            dm_reg <= {4'd0, delta_reg} * {32'd0, sct_pkg::speed_mult(speed_mode)};
        end
        else if (mul_cnt_reg == 2'd1)
        begin
            prod_reg <= {20'd0, dm_reg} * {36'd0, game_seconds_per_day};
        end
        if (!scan_idx_reg[SW] && cand)
        begin
            best_reg     <= cur;
            best_due_reg <= due_reg[cur];
            best_age_reg <= cur_age;
        end
        if (ctrl.fire && per_reg[best_reg] != '0)
        begin
            due_reg[best_reg] <= sct_pkg::sat_add(due_reg[best_reg], per_reg[best_reg]);
        end
        if (ctrl.do_cmd && cmd_kind == sct_pkg::KIND_ADDED)
        begin
            due_reg[free_idx] <= (cmd_reg == sct_pkg::CMD_ADD_ONE)
                                 ? due_in_reg : sct_pkg::sat_add(time_reg, per_in_reg);
            per_reg[free_idx] <= (cmd_reg == sct_pkg::CMD_ADD_ONE) ? '0 : per_in_reg;
            hdl_reg[free_idx] <= nh_reg;
        end
        if (ctrl.fire)
        begin
            kind_reg   <= sct_pkg::KIND_FIRED;
            handle_reg <= hdl_reg[best_reg];
        end
        else if (ctrl.do_cmd)
        begin
            kind_reg   <= cmd_kind;
            handle_reg <= cmd_handle;
        end
        else if (ctrl.set_done)
        begin
            kind_reg   <= sct_pkg::KIND_DONE;
            handle_reg <= '0;
        end
        if (ctrl.day_start)
        begin
            day_zero_reg <= (game_seconds_per_day == '0);
        end
        if (ctrl.out_load)
        begin
            now_reg <= time_reg;
            day_reg <= day_zero_reg ? 32'd0 : div_q[31:0];
            tod_reg <= day_zero_reg ? time_reg[35:0] : div_r[35:0];
        end
        div_day_reg <= ctrl.day_start;
    end

    assign stat.cmd       = sct_pkg::cmd_t'(cmd_reg);
    assign stat.mul_busy  = (mul_cnt_reg != 2'd0) || ctrl.mul_start;
    assign stat.div_busy  = div_busy || ctrl.div_start;
    assign stat.scan_busy = !scan_idx_reg[SW] || ctrl.scan_start;
    assign stat.found     = best_ok_reg;
    assign stat.day_busy  = div_busy || div_day_reg;

    assign kind        = kind_reg;
    assign handle      = handle_reg;
    assign now_time    = now_reg;
    assign day_index   = day_reg;
    assign time_of_day = tod_reg;
endmodule

FILE: design/sct_ctrl.sv
// Controller state machine: sequences advance, fire loop, commands and result beats.
// Depends on sct_pkg.
module sct_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_last,
    output sct_pkg::dp_ctrl_t  ctrl,
    input  sct_pkg::dp_stat_t  stat
);
    sct_pkg::state_t state_reg, state_next;
    logic [sct_pkg::FIRE_W-1:0] fires_reg, fires_next;
    logic last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sct_pkg::ST_IDLE;
            fires_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fires_reg <= fires_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fires_next = fires_reg;
        last_next  = last_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            sct_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = sct_pkg::ST_MUL;
                end
            end
            sct_pkg::ST_MUL:
            begin
                if (stat.cmd == sct_pkg::CMD_ADVANCE)
                begin
                    ctrl.mul_start = 1'b1;
                    fires_next     = '0;
                    state_next     = sct_pkg::ST_DIV;
                end
                else
                begin
                    ctrl.do_cmd = 1'b1;
                    last_next   = 1'b1;
                    state_next  = sct_pkg::ST_DAY;
                end
            end
            sct_pkg::ST_DIV:
            begin
                if (!stat.mul_busy)
                begin
                    ctrl.div_start = 1'b1;
                    state_next     = sct_pkg::ST_SCAN;
                end
            end
            sct_pkg::ST_SCAN:
            begin
                if (!stat.div_busy)
                begin
                    ctrl.add_inc    = 1'b1;
                    ctrl.scan_start = 1'b1;
                    state_next      = sct_pkg::ST_PICK;
                end
            end
            sct_pkg::ST_PICK:
            begin
                if (!stat.scan_busy)
                begin
                    if (stat.found && fires_reg != sct_pkg::FIRE_W'(sct_pkg::MAX_FIRES))
                    begin
                        ctrl.fire  = 1'b1;
                        fires_next = fires_reg + sct_pkg::FIRE_W'(1);
                        last_next  = 1'b0;
                    end
                    else
                    begin
                        ctrl.set_done = 1'b1;
                        last_next     = 1'b1;
                    end
                    state_next = sct_pkg::ST_DAY;
                end
            end
            sct_pkg::ST_DAY:
            begin
                ctrl.day_start = 1'b1;
                state_next     = sct_pkg::ST_WAIT;
            end
            sct_pkg::ST_WAIT:
            begin
                if (!stat.day_busy)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = sct_pkg::ST_OUT;
                end
            end
            sct_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_reg)
                    begin
                        state_next = sct_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ctrl.scan_start = 1'b1;
                        state_next      = sct_pkg::ST_PICK;
                    end
                end
            end
            default:
            begin
                state_next = sct_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_last = last_reg;
endmodule

FILE: design/sct_regs.sv
// APB configuration registers: speed mode and day length settings.
// Depends on sct_pkg.
module sct_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic [2:0]  speed_mode,
    output logic [19:0] game_seconds_per_day,
    output logic [19:0] real_seconds_per_day
);
    logic [2:0]  speed_reg;
    logic [19:0] game_reg, real_reg;
    logic        wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 3'd1;
            game_reg  <= 20'd86400;
            real_reg  <= 20'd1440;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                sct_pkg::REG_SPEED: speed_reg <= pwdata[2:0];
                sct_pkg::REG_GAME:  game_reg  <= pwdata[19:0];
                sct_pkg::REG_REAL:  real_reg  <= pwdata[19:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            sct_pkg::REG_SPEED: prdata = {29'd0, speed_reg};
            sct_pkg::REG_GAME:  prdata = {12'd0, game_reg};
            sct_pkg::REG_REAL:  prdata = {12'd0, real_reg};
            default:            prdata = '0;
        endcase
    end

    assign speed_mode           = speed_reg;
    assign game_seconds_per_day = game_reg;
    assign real_seconds_per_day = real_reg;
endmodule

FILE: design/scaled_clock_timer_scheduler.sv
// Top level of the scaled clock timer scheduler.
// Depends on sct_pkg, sct_regs, sct_ctrl, sct_datapath.
// One item at a time. Add and cancel are bounded by the 64-step day-length divide
// behind every result beat. An advance first runs the multiply and the 64-step scaled
// increment divide, then for every result beat the slot scan plus the day divide;
// the shared radix-2 divider does both divides.
module scaled_clock_timer_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] real_delta,
    input  logic [47:0] due_time,
    input  logic [47:0] period,
    input  logic [30:0] target_handle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [30:0] handle,
    output logic [47:0] now_time,
    output logic [31:0] day_index,
    output logic [35:0] time_of_day,
    output logic        last
);
    logic [2:0]  speed_mode;
    logic [19:0] game_seconds_per_day;
    logic [19:0] real_seconds_per_day;
    sct_pkg::dp_ctrl_t ctrl;
    sct_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    sct_regs u_regs (
        .clk                  (clk),
        .rst_n                (rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .speed_mode           (speed_mode),
        .game_seconds_per_day (game_seconds_per_day),
        .real_seconds_per_day (real_seconds_per_day)
    );

    sct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (last),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    sct_datapath u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctrl                 (ctrl),
        .stat                 (stat),
        .cmd                  (cmd),
        .real_delta           (real_delta),
        .due_time             (due_time),
        .period               (period),
        .target_handle        (target_handle),
        .speed_mode           (speed_mode),
        .game_seconds_per_day (game_seconds_per_day),
        .real_seconds_per_day (real_seconds_per_day),
        .kind                 (kind),
        .handle               (handle),
        .now_time             (now_time),
        .day_index            (day_index),
        .time_of_day          (time_of_day)
    );
endmodule
